>>> rtl/dmpid_pkg.sv
// shared types, widths and register map for the dual mode pid controller
`default_nettype none

package dmpid_pkg;

    localparam int unsigned SampleWidth = 16;
    localparam int unsigned ErrorWidth  = SampleWidth + 1;
    localparam int unsigned DeltaWidth  = SampleWidth + 2;
    localparam int unsigned GainWidth   = 16;
    localparam int unsigned LimitWidth  = 15;
    localparam int unsigned SumWidth    = 32;
    localparam int unsigned AddrWidth   = 5;
    localparam int unsigned DataWidth   = 32;

    typedef enum logic [2:0] {
        REG_ANGLE_MODE     = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_OUTPUT_LIMIT   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                          angle_mode;
        logic signed [GainWidth-1:0]   gain_p;
        logic signed [GainWidth-1:0]   gain_i;
        logic signed [GainWidth-1:0]   gain_d;
        logic        [LimitWidth-1:0]  integral_limit;
        logic        [LimitWidth-1:0]  output_limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/dmpid_terms.sv
// gain products, integral clamp, term sum and output clamp for one item
`default_nettype none

module dmpid_terms
    import dmpid_pkg::*;
(
    input  var cfg_t                         cfg,
    input  wire logic signed [ErrorWidth-1:0] error,
    input  wire logic signed [DeltaWidth-1:0] delta,
    input  wire logic signed [SumWidth-1:0]   integral_sum,
    output logic signed [SampleWidth-1:0]     drive,
    output logic                              clamped
);

    localparam int unsigned ProdPWidth = GainWidth + ErrorWidth;
    localparam int unsigned ProdDWidth = GainWidth + DeltaWidth;
    localparam int unsigned ProdIWidth = GainWidth + SumWidth;
    localparam int unsigned TotalWidth = ProdDWidth - 8 + 2;

    logic signed [ProdPWidth-1:0]   prod_p;
    logic signed [ProdDWidth-1:0]   prod_d;
    logic signed [ProdIWidth-1:0]   prod_i;
    logic signed [ProdIWidth-9:0]   shifted_i;
    logic signed [ProdIWidth-9:0]   ilim_pos;
    logic signed [ProdIWidth-9:0]   ilim_neg;
    logic signed [SampleWidth-1:0]  term_i;
    logic signed [TotalWidth-1:0]   total;
    logic signed [TotalWidth-1:0]   olim_pos;
    logic signed [TotalWidth-1:0]   olim_neg;

    always_comb
    begin
        prod_p = ProdPWidth'(cfg.gain_p) * ProdPWidth'(error);
        prod_d = ProdDWidth'(cfg.gain_d) * ProdDWidth'(delta);
        prod_i = ProdIWidth'(cfg.gain_i) * ProdIWidth'(integral_sum);

        // dropping the low byte is the floor shift
        shifted_i = prod_i[ProdIWidth-1:8];
        ilim_pos  = $signed({{(ProdIWidth-8-LimitWidth){1'b0}}, cfg.integral_limit});
        ilim_neg  = -ilim_pos;

        priority if (shifted_i > ilim_pos)
        begin
            term_i = SampleWidth'(ilim_pos);
        end
        else if (shifted_i < ilim_neg)
        begin
            term_i = SampleWidth'(ilim_neg);
        end
        else
        begin
            term_i = SampleWidth'(shifted_i);
        end

        total = TotalWidth'($signed(prod_p[ProdPWidth-1:8]))
              + TotalWidth'($signed(prod_d[ProdDWidth-1:8]))
              + TotalWidth'(term_i);

        olim_pos = $signed({{(TotalWidth-LimitWidth){1'b0}}, cfg.output_limit});
        olim_neg = -olim_pos;

        priority if (total > olim_pos)
        begin
            drive   = SampleWidth'(olim_pos);
            clamped = 1'b1;
        end
        else if (total < olim_neg)
        begin
            drive   = SampleWidth'(olim_neg);
            clamped = 1'b1;
        end
        else
        begin
            drive   = SampleWidth'(total);
            clamped = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dual_mode_pid_controller_core.sv
// top level of the dual mode pid controller: handshakes, state and register file
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+---------------------------------
//  s_axis    | in        | tvalid / tready                | tdata: four 16-bit samples
//  m_axis    | out       | tvalid / tready                | tdata: drive, tuser: clamped
//  apb       | in        | psel / penable / pwrite, ready | six control registers
//
// one item per cycle unless m_axis stalls; items pass input, stage one and result registers
// stage one forms the error, the derivative input and the saturated integral,
// stage two does the three gain products and both clamps into the result register
// integral sum and previous error change only when an item leaves the input register
// each stage holds while the one after it is full and stalled; reset clears state to zero

`default_nettype none

module dual_mode_pid_controller_core
    import dmpid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // angle_target, angle_feedback, speed_target, speed_feedback
    input  wire logic [63:0]           s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // drive
    output logic [15:0]                m_axis_tdata,
    // clamped
    output logic                       m_axis_tuser,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [AddrWidth-1:0]  paddr,
    input  wire logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]       prdata,
    output logic                       pready
);

    cfg_t                           cfg_reg;
    reg_index_t                     reg_sel;
    logic                           cfg_write;

    logic                           in_valid_reg;
    logic signed [SampleWidth-1:0]  angle_target_reg;
    logic signed [SampleWidth-1:0]  angle_feedback_reg;
    logic signed [SampleWidth-1:0]  speed_target_reg;
    logic signed [SampleWidth-1:0]  speed_feedback_reg;

    logic                           mid_valid_reg;
    logic signed [DeltaWidth-1:0]   mid_delta_reg;
    logic signed [DeltaWidth-1:0]   mid_delta_next;
    logic signed [ErrorWidth-1:0]   prev_error_reg;
    logic signed [ErrorWidth-1:0]   prev_error_next;
    logic signed [SumWidth-1:0]     integral_sum_reg;
    logic signed [SumWidth-1:0]     integral_sum_next;
    logic signed [SumWidth:0]       integral_wide;

    logic                           out_valid_reg;
    logic signed [SampleWidth-1:0]  drive_reg;
    logic                           clamped_reg;
    logic signed [SampleWidth-1:0]  drive_next;
    logic                           clamped_next;

    logic                           out_ready;
    logic                           mid_ready;
    logic                           in_ready;
    logic                           in_fire;
    logic                           in_adv;
    logic                           mid_adv;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_mode     <= 1'b0;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '1;
            cfg_reg.output_limit   <= '1;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_ANGLE_MODE:     cfg_reg.angle_mode     <= pwdata[0];
                REG_GAIN_P:         cfg_reg.gain_p         <= pwdata[GainWidth-1:0];
                REG_GAIN_I:         cfg_reg.gain_i         <= pwdata[GainWidth-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= pwdata[GainWidth-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= pwdata[LimitWidth-1:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= pwdata[LimitWidth-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ANGLE_MODE:     prdata = DataWidth'(cfg_reg.angle_mode);
            REG_GAIN_P:         prdata = DataWidth'(cfg_reg.gain_p);
            REG_GAIN_I:         prdata = DataWidth'(cfg_reg.gain_i);
            REG_GAIN_D:         prdata = DataWidth'(cfg_reg.gain_d);
            REG_INTEGRAL_LIMIT: prdata = DataWidth'(cfg_reg.integral_limit);
            REG_OUTPUT_LIMIT:   prdata = DataWidth'(cfg_reg.output_limit);
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline flow ----------------
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign mid_ready     = !mid_valid_reg || out_ready;
    assign in_ready      = !in_valid_reg || mid_ready;
    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;
    assign in_adv        = in_valid_reg && mid_ready;
    assign mid_adv       = mid_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_adv)
            begin
                in_valid_reg <= 1'b0;
            end

            if (in_adv)
            begin
                mid_valid_reg <= 1'b1;
            end
            else if (mid_adv)
            begin
                mid_valid_reg <= 1'b0;
            end

            if (mid_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            angle_target_reg   <= s_axis_tdata[15:0];
            angle_feedback_reg <= s_axis_tdata[31:16];
            speed_target_reg   <= s_axis_tdata[47:32];
            speed_feedback_reg <= s_axis_tdata[63:48];
        end
    end

    // ---------------- stage one: error, derivative input, integral ----------------
    always_comb
    begin
        if (cfg_reg.angle_mode)
        begin
            prev_error_next = ErrorWidth'(angle_target_reg) - ErrorWidth'(angle_feedback_reg);
            mid_delta_next  = DeltaWidth'(speed_target_reg);
        end
        else
        begin
            prev_error_next = ErrorWidth'(speed_target_reg) - ErrorWidth'(speed_feedback_reg);
            mid_delta_next  = DeltaWidth'(prev_error_next) - DeltaWidth'(prev_error_reg);
        end

        integral_wide = (SumWidth+1)'(integral_sum_reg) + (SumWidth+1)'(prev_error_next);

        // top two bits disagree on overflow; the top bit gives its direction
        if (integral_wide[SumWidth] != integral_wide[SumWidth-1])
        begin
            integral_sum_next = integral_wide[SumWidth] ?
                {1'b1, {(SumWidth-1){1'b0}}} : {1'b0, {(SumWidth-1){1'b1}}};
        end
        else
        begin
            integral_sum_next = integral_wide[SumWidth-1:0];
        end
    end

    // the state registers double as the stage two operands of the item in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg   <= '0;
            integral_sum_reg <= '0;
        end
        else if (in_adv)
        begin
            prev_error_reg   <= prev_error_next;
            integral_sum_reg <= integral_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            mid_delta_reg <= mid_delta_next;
        end
    end

    // ---------------- stage two: products and clamps ----------------
    dmpid_terms u_terms (
        .cfg          (cfg_reg),
        .error        (prev_error_reg),
        .delta        (mid_delta_reg),
        .integral_sum (integral_sum_reg),
        .drive        (drive_next),
        .clamped      (clamped_next)
    );

    always_ff @(posedge clk)
    begin
        if (mid_adv)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_reg;
    assign m_axis_tuser  = clamped_reg;

`ifndef SYNTH
    logic signed [SampleWidth-1:0] olim_s;
    assign olim_s = $signed({1'b0, cfg_reg.output_limit});

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg <= olim_s) && (drive_reg >= -olim_s))
        else $error("drive outside the output limit");

    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clamped_reg) |-> (drive_reg == olim_s) || (drive_reg == -olim_s))
        else $error("clamped item does not sit on the output limit");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_adv |=> $stable(integral_sum_reg) && $stable(prev_error_reg))
        else $error("loop state changed without an item moving");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && mid_valid_reg && out_valid_reg)
        else $error("input stalled while a stage was empty");
`endif

endmodule

`default_nettype wire

>>> bench/pid_drive_checker.sv
// watches the pid controller channels, predicts each drive value and compares it

module pid_drive_checker
    import dmpid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    // angle_target, angle_feedback, speed_target, speed_feedback
    input  wire logic [63:0]          s_axis_tdata,

    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // drive
    input  wire logic [15:0]          m_axis_tdata,
    // clamped
    input  wire logic                 m_axis_tuser,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic                 pready,
    input  wire logic [AddrWidth-1:0] paddr,
    input  wire logic [DataWidth-1:0] pwdata,

    output int unsigned               mismatches,
    output int unsigned               pending,
    output int unsigned               drives_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SumMax = 64'sd2147483647;
    localparam longint SumMin = -SumMax - 1;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } drive_result_t;

    cfg_t                settings;
    logic signed [16:0]  prev_error;
    logic signed [31:0]  integral_sum;
    drive_result_t       predicted_drives[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // advances the loop state by one sample and returns the drive it gives
    function automatic drive_result_t predict_drive(input logic [63:0] sample);
        longint angle_target, angle_feedback, speed_target, speed_feedback;
        longint err, delta, acc, i_term, total, lim;
        drive_result_t r;
        angle_target   = longint'($signed(sample[15:0]));
        angle_feedback = longint'($signed(sample[31:16]));
        speed_target   = longint'($signed(sample[47:32]));
        speed_feedback = longint'($signed(sample[63:48]));
        if (settings.angle_mode) begin
            err   = angle_target - angle_feedback;
            delta = speed_target;
        end
        else begin
            err   = speed_target - speed_feedback;
            delta = err - longint'(prev_error);
        end
        acc = longint'(integral_sum) + err;
        if (acc > SumMax)
            acc = SumMax;
        else if (acc < SumMin)
            acc = SumMin;
        integral_sum = acc[31:0];

        lim    = longint'(settings.integral_limit);
        i_term = (longint'($signed(settings.gain_i)) * acc) >>> 8;
        if (i_term > lim)
            i_term = lim;
        else if (i_term < -lim)
            i_term = -lim;

        total = ((longint'($signed(settings.gain_p)) * err) >>> 8)
              + ((longint'($signed(settings.gain_d)) * delta) >>> 8) + i_term;
        lim       = longint'(settings.output_limit);
        r.clamped = 1'b0;
        if (total > lim) begin
            total     = lim;
            r.clamped = 1'b1;
        end
        else if (total < -lim) begin
            total     = -lim;
            r.clamped = 1'b1;
        end
        r.drive    = total[15:0];
        prev_error = err[16:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_result_t want;
        if (!rst_n)
        begin
            settings.angle_mode     = 1'b0;
            settings.gain_p         = '0;
            settings.gain_i         = '0;
            settings.gain_d         = '0;
            settings.integral_limit = '1;
            settings.output_limit   = '1;
            prev_error              = '0;
            integral_sum            = '0;
            predicted_drives.delete();
        end
        else
        begin
            // results go first: no result can come from an item taken at this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_drives.size() == 0)
                begin
                    report_mismatch($sformatf("drive %0d with no sample waiting",
                                              $signed(m_axis_tdata)));
                end
                else
                begin
                    want = predicted_drives.pop_front();
                    if (m_axis_tdata !== want.drive)
                        report_mismatch($sformatf("drive %0d, expected %0d",
                                                  $signed(m_axis_tdata), want.drive));
                    if (m_axis_tuser !== want.clamped)
                        report_mismatch($sformatf("clamped %b, expected %b",
                                                  m_axis_tuser, want.clamped));
                    drives_seen++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[AddrWidth-1:2])
                    REG_ANGLE_MODE:     settings.angle_mode     = pwdata[0];
                    REG_GAIN_P:         settings.gain_p         = pwdata[GainWidth-1:0];
                    REG_GAIN_I:         settings.gain_i         = pwdata[GainWidth-1:0];
                    REG_GAIN_D:         settings.gain_d         = pwdata[GainWidth-1:0];
                    REG_INTEGRAL_LIMIT: settings.integral_limit = pwdata[LimitWidth-1:0];
                    REG_OUTPUT_LIMIT:   settings.output_limit   = pwdata[LimitWidth-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_drives.push_back(predict_drive(s_axis_tdata));
        end
        pending = predicted_drives.size();
    end

endmodule

>>> bench/testbench.sv
// stimulus, clock, reset and verdict for the dual mode pid controller core

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dmpid_pkg::*;

    localparam int unsigned CycleLimit   = 1_000_000;
    localparam int unsigned IdlePercent  = 13;
    localparam int unsigned DrainCycles  = 20;
    localparam int unsigned WindupSteps  = 40;
    localparam int unsigned RandomPhases = 6;
    localparam int unsigned PhaseItems   = 113;
    localparam logic [2:0]  SpareIndexA  = 3'd6;
    localparam logic [2:0]  SpareIndexB  = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [AddrWidth-1:0] paddr         = '0;
    logic [DataWidth-1:0] pwdata        = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    bit                   steady = 1'b0;
    int unsigned          cycle_count;
    int unsigned          samples_sent;
    int unsigned          settings_written;
    int unsigned          mismatches;
    int unsigned          pending;
    int unsigned          drives_seen;

    dual_mode_pid_controller_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pid_drive_checker drive_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .drives_seen   (drives_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    task automatic send_sample(input logic [15:0] angle_target, angle_feedback,
                               input logic [15:0] speed_target, speed_feedback);
        while (!steady && $urandom_range(0, 99) < IdlePercent)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {speed_feedback, speed_target, angle_feedback, angle_target};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // stop sending and let every outstanding drive come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [DataWidth-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    // junk in the unused upper bits must be ignored by the block
    task automatic apply_settings(input logic mode, input logic [15:0] kp, ki, kd,
                                  input logic [14:0] i_limit, o_limit);
        write_register(REG_ANGLE_MODE, {31'($urandom), mode});
        write_register(REG_GAIN_P, {16'($urandom), kp});
        write_register(REG_GAIN_I, {16'($urandom), ki});
        write_register(REG_GAIN_D, {16'($urandom), kd});
        write_register(REG_INTEGRAL_LIMIT, {17'($urandom), i_limit});
        write_register(REG_OUTPUT_LIMIT, {17'($urandom), o_limit});
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0:          return 16'h7fff;
            1:          return 16'h8000;
            2:          return 16'h0000;
            3, 4, 5:    return 16'($urandom_range(0, 1024)) - 16'd512;
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_limit();
        case ($urandom_range(0, 9))
            0:          return 15'd0;
            1:          return 15'h7fff;
            2, 3, 4, 5: return 15'($urandom_range(0, 2000));
            default:    return 15'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gains come out of reset at zero, so these drive zero
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        wait_drained();

        apply_settings(1'b0, 16'h7fff, 16'h8000, 16'h7fff, 15'h7fff, 15'h7fff);
        // writes to unmapped registers must change nothing
        write_register(SpareIndexA, $urandom);
        write_register(SpareIndexB, $urandom);
        send_sample(16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        send_sample(16'h0000, 16'h0000, 16'h8000, 16'h7fff);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        wait_drained();

        // switch to the angle loop: speed target becomes the rate term
        apply_settings(1'b1, 16'h8000, 16'h0001, 16'h8000, 15'd1000, 15'd20000);
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h0000);
        send_sample(16'h1234, 16'h1200, 16'hffff, 16'h5555);
        wait_drained();

        // back to the speed loop with both limits at zero
        apply_settings(1'b0, 16'h0100, 16'h0010, 16'h0200, 15'd0, 15'd0);
        send_sample(16'h0000, 16'h0000, 16'h0064, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0064, 16'h0064);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();

        // wind the integral up with full scale errors, down past zero and back;
        // the integral term follows the running sum the whole way
        apply_settings(1'b0, 16'h0000, 16'h0001, 16'h0000, 15'h7fff, 15'h7fff);
        steady <= 1'b1;
        repeat (WindupSteps) send_sample(16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        repeat (2 * WindupSteps) send_sample(16'h0000, 16'h0000, 16'h8000, 16'h7fff);
        repeat (WindupSteps) send_sample(16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        wait_drained();
        steady <= 1'b0;

        for (int unsigned phase = 0; phase < RandomPhases; phase++)
        begin
            apply_settings(phase[0], pick_gain(), pick_gain(), pick_gain(),
                           pick_limit(), pick_limit());
            steady <= (phase == 2);
            repeat (PhaseItems)
                send_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            wait_drained();
        end
        steady <= 1'b0;

        repeat (DrainCycles) @(posedge clk);
        $display("sent %0d samples under %0d register writes: both loop modes, gain and limit",
                 samples_sent, settings_written);
        $display("extremes, integral wind-up and unwind; %0d drive values compared",
                 drives_seen);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
